[rtl/trivium_keystream_xor_top_defines.svh]
// ----------------------------------------------------------------------------
// trivium keystream xor assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef TRIVIUM_KEYSTREAM_XOR_TOP_DEFINES_SVH
`define TRIVIUM_KEYSTREAM_XOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define TRV_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);
// checked at every edge, reset included
`define TRV_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define TRV_ASSERT(lbl, clk_sig, rstn_sig, prop, msg)
`define TRV_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif

`endif

[rtl/trv_pkg.sv]
// ----------------------------------------------------------------------------
// trivium package
// shared widths, register indexes and types
// ----------------------------------------------------------------------------
package trv_pkg;

  localparam int StateW       = 288;
  localparam int CellW        = 8;
  localparam int NumCells     = StateW / CellW;
  localparam int KeyW         = 80;
  localparam int IvBase       = 93;
  localparam int RegBBase     = 93;
  localparam int RegCBase     = 177;
  localparam int WarmupRounds = 1152;
  localparam int WarmupCycles = WarmupRounds / CellW;
  localparam int WarmCntW     = $clog2(WarmupCycles + 1);

  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 2;
  localparam int HalfW    = 16;

  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIvHigh  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIvLow   = 2'd3;

  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_DATA    = 1'b1;

  typedef logic [CellW-1:0]  byte_t;
  typedef logic [StateW-1:0] state_t;

  // one byte per field, bit r belongs to round r of the cycle
  typedef struct packed {
    byte_t ks;
    byte_t n1;
    byte_t n2;
    byte_t n3;
  } trv_fb_t;

  typedef struct packed {
    logic load;
    logic adv;
  } cell_ctl_t;

endpackage

[rtl/trv_cell.sv]
// ----------------------------------------------------------------------------
// trivium state cell
// one byte of the cipher state, loaded on restart or shifted from its neighbor
// ----------------------------------------------------------------------------
module trv_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trv_pkg::cell_ctl_t   ctl,
  input  trv_pkg::byte_t       load_val,
  input  trv_pkg::byte_t       shift_in,
  output trv_pkg::byte_t       q
);

  trv_pkg::byte_t q_r;
  trv_pkg::byte_t q_nxt;

  always_comb begin
    priority if (ctl.load) begin
      q_nxt = load_val;
    end else if (ctl.adv) begin
      q_nxt = shift_in;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/trv_update.sv]
// ----------------------------------------------------------------------------
// trivium eight-round update
// keystream and feedback bits of eight rounds, all taken from the current state
// ----------------------------------------------------------------------------
module trv_update (
  input  trv_pkg::state_t  state,
  output trv_pkg::trv_fb_t fb
);

  always_comb begin
    logic t1;
    logic t2;
    logic t3;
    fb = '0;
    for (int r = 0; r < trv_pkg::CellW; r++) begin
      t1 = state[65 - r] ^ state[92 - r];
      t2 = state[161 - r] ^ state[176 - r];
      t3 = state[242 - r] ^ state[287 - r];
      fb.ks[r] = t1 ^ t2 ^ t3;
      fb.n1[r] = t1 ^ (state[90 - r] & state[91 - r]) ^ state[170 - r];
      fb.n2[r] = t2 ^ (state[174 - r] & state[175 - r]) ^ state[263 - r];
      fb.n3[r] = t3 ^ (state[285 - r] & state[286 - r]) ^ state[68 - r];
    end
  end

endmodule

[rtl/trivium_keystream_xor_top.sv]
// ----------------------------------------------------------------------------
// trivium keystream xor top
// byte-wide trivium: byte cells advanced eight rounds per warm-up or data cycle
// ----------------------------------------------------------------------------
//  channel  ports                               direction  transfer
//  in       in_valid in_stall in_mode           sink       valid & !stall
//           in_data_byte
//  out      out_valid out_stall out_byte        source     valid & !stall
//  cfg      cfg_we cfg_index cfg_wdata          sink       cfg_we
//
//  a data byte is xored with keystream from the eight-round update unit;
//  bytes can follow back to back while in_stall is low, and each result is
//  registered in the output register, or in the skid entry on a stall.
//  a restart loads the cells, then runs 1152 warm-up rounds, in_stall high.
//  rst_n is synchronous and clears state, key, iv, the warm-up counter and
//  the output valid flags. an output register plus a skid entry keep input
//  flowing; in_stall rises during warm-up or once the skid entry is full.
// ----------------------------------------------------------------------------
`include "trivium_keystream_xor_top_defines.svh"

module trivium_keystream_xor_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [7:0]                   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  input  logic                         cfg_we,
  input  logic [trv_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [trv_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [trv_pkg::HalfW-1:0]    key_high_r;
  logic [trv_pkg::CfgDataW-1:0] key_low_r;
  logic [trv_pkg::HalfW-1:0]    iv_high_r;
  logic [trv_pkg::CfgDataW-1:0] iv_low_r;

  logic [trv_pkg::WarmCntW-1:0] warm_cnt_r;
  logic [trv_pkg::WarmCntW-1:0] warm_cnt_nxt;

  logic           out_valid_r;
  logic           out_valid_nxt;
  trv_pkg::byte_t out_byte_r;
  trv_pkg::byte_t out_byte_nxt;
  logic           skid_valid_r;
  logic           skid_valid_nxt;
  trv_pkg::byte_t skid_byte_r;
  trv_pkg::byte_t skid_byte_nxt;

  logic               busy;
  logic               in_xfer;
  logic               restart_xfer;
  logic               data_xfer;
  logic               out_free;
  trv_pkg::byte_t     res_byte;
  trv_pkg::state_t    state;
  trv_pkg::state_t    load_vec;
  trv_pkg::state_t    shift_vec;
  trv_pkg::trv_fb_t   fb;
  trv_pkg::cell_ctl_t cell_ctl;
  logic [trv_pkg::KeyW-1:0] key80;
  logic [trv_pkg::KeyW-1:0] iv80;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trv_pkg::CfgKeyHigh: key_high_r <= cfg_wdata[trv_pkg::HalfW-1:0];
        trv_pkg::CfgKeyLow:  key_low_r  <= cfg_wdata;
        trv_pkg::CfgIvHigh:  iv_high_r  <= cfg_wdata[trv_pkg::HalfW-1:0];
        trv_pkg::CfgIvLow:   iv_low_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key80 = {key_high_r, key_low_r};
  assign iv80  = {iv_high_r, iv_low_r};

  // handshake
  assign busy         = (warm_cnt_r != '0);
  assign in_stall     = busy || skid_valid_r;
  assign in_xfer      = in_valid && !in_stall;
  assign restart_xfer = in_xfer && (in_mode == trv_pkg::MODE_RESTART);
  assign data_xfer    = in_xfer && (in_mode == trv_pkg::MODE_DATA);

  // warm-up counter
  always_comb begin
    priority if (restart_xfer) begin
      warm_cnt_nxt = trv_pkg::WarmCntW'(trv_pkg::WarmupCycles);
    end else if (busy) begin
      warm_cnt_nxt = warm_cnt_r - 1'b1;
    end else begin
      warm_cnt_nxt = warm_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else begin
      warm_cnt_r <= warm_cnt_nxt;
    end
  end

  // restart image: key msb first from bit 0, iv from bit 93, top three set
  always_comb begin
    load_vec = '0;
    for (int j = 0; j < trv_pkg::KeyW; j++) begin
      load_vec[j]                  = key80[trv_pkg::KeyW - 1 - j];
      load_vec[trv_pkg::IvBase + j] = iv80[trv_pkg::KeyW - 1 - j];
    end
    load_vec[trv_pkg::StateW-1 -: 3] = 3'b111;
  end

  // shift by one byte, feedback bits inserted at the head of each register
  always_comb begin
    shift_vec = {state[trv_pkg::StateW-trv_pkg::CellW-1:0], trv_pkg::byte_t'(0)};
    for (int b = 0; b < trv_pkg::CellW; b++) begin
      shift_vec[b]                     = fb.n3[trv_pkg::CellW - 1 - b];
      shift_vec[trv_pkg::RegBBase + b] = fb.n1[trv_pkg::CellW - 1 - b];
      shift_vec[trv_pkg::RegCBase + b] = fb.n2[trv_pkg::CellW - 1 - b];
    end
  end

  assign cell_ctl.load = restart_xfer;
  assign cell_ctl.adv  = busy || data_xfer;

  trv_update u_update (
    .state (state),
    .fb    (fb)
  );

  for (genvar c = 0; c < trv_pkg::NumCells; c++) begin : g_cell
    trv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .load_val (load_vec[c*trv_pkg::CellW +: trv_pkg::CellW]),
      .shift_in (shift_vec[c*trv_pkg::CellW +: trv_pkg::CellW]),
      .q        (state[c*trv_pkg::CellW +: trv_pkg::CellW])
    );
  end

  // output register and skid entry
  assign res_byte = in_data_byte ^ fb.ks;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    skid_valid_nxt = skid_valid_r;
    skid_byte_nxt  = skid_byte_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || data_xfer;
      out_byte_nxt   = skid_valid_r ? skid_byte_r : res_byte;
      skid_valid_nxt = 1'b0;
    end else if (data_xfer) begin
      skid_valid_nxt = 1'b1;
      skid_byte_nxt  = res_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    skid_byte_r <= skid_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // checks
  `TRV_ASSERT(a_skid_behind_out, clk, rst_n,
    skid_valid_r |-> out_valid_r, "skid entry without output")
  `TRV_ASSERT(a_restart_warmup, clk, rst_n,
    restart_xfer |=> (warm_cnt_r == trv_pkg::WarmCntW'(trv_pkg::WarmupCycles)),
    "warm-up not started")
  `TRV_ASSERT(a_data_result, clk, rst_n,
    data_xfer |=> out_valid_r, "data transfer lost its result")
  `TRV_ASSERT(a_drain, clk, rst_n,
    (out_valid_r && !out_stall && !skid_valid_r && !data_xfer) |=> !out_valid_r,
    "result repeated")

endmodule
